// ----- src/dpbt_pkg.sv -----
`default_nettype none

package dpbt_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_BITS    = 12;
    localparam int MV_BITS        = 12;
    localparam int DENSITY_BITS   = 10;
    localparam int WINDOW_BITS    = 8;
    localparam int COEF_BITS      = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    // Default fraction width of the baseline in millivolts.
    localparam int FRAC_BITS_DEFAULT = 16;

    // Conversion and filter constants.
    localparam int MV_FULL     = 2600;
    localparam int MV_RESET    = 900;
    localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
    localparam int COEF_SHIFT  = 16;
    localparam int DIV5_RECIP  = 13108;
    localparam int DIV5_SHIFT  = 16;
    localparam int DENSITY_MAX = 520;

    // Register reset values.
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 8'd20;
    localparam logic [COEF_BITS-1:0]   COEF_RESET   = 16'd66;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_COEF    = 4'd1;

    // Input word.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] adc_sample;
        logic                   sample_ok;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [DENSITY_BITS-1:0] density_ugm3;
        logic                    reading_valid;
        logic [MV_BITS-1:0]      baseline_mv;
    } out_word_t;

    // Sequencer of the window-end arithmetic.
    typedef enum logic [2:0] {
        CALC_IDLE,
        CALC_MUL,
        CALC_DIV,
        CALC_DECAY,
        CALC_UPDATE,
        CALC_DENS,
        CALC_DONE
    } calc_state_t;

    // Controls from the top level to the arithmetic unit.
    typedef struct packed {
        logic start;
        logic take;
    } calc_ctrl_t;

    // Status from the arithmetic unit to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } calc_status_t;

endpackage

`default_nettype wire

// ----- src/dpbt_calc.sv -----
`default_nettype none

module dpbt_calc
    import dpbt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire calc_ctrl_t             ctrl,
    input  wire logic [SAMPLE_BITS-1:0] peak,
    input  wire logic [COEF_BITS-1:0]   coef,
    output calc_status_t                status,
    output out_word_t                   result
);

    localparam int BW  = MV_BITS + FRAC_BITS;
    localparam int QW  = BW;
    localparam int PW  = SAMPLE_BITS + MV_BITS;
    localparam int NW  = PW + FRAC_BITS;
    localparam int FOLD_STEPS = 5;
    localparam int CW  = $clog2(FOLD_STEPS);
    localparam int DW  = BW + COEF_BITS;
    localparam int EW  = MV_BITS + DIV5_SHIFT;

    localparam logic [BW-1:0] BASE_RESET = BW'(MV_RESET) << FRAC_BITS;
    localparam logic [NW-1:0] ROUND_HALF = NW'(FULL_SCALE / 2);

    calc_state_t              state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [SAMPLE_BITS-1:0]   peak_reg, peak_next;
    logic [NW-1:0]            rem_reg, rem_next;
    logic [QW-1:0]            quo_reg, quo_next;
    logic [BW-1:0]            baseline_reg, baseline_next;
    logic [DW-1:0]            dprod_reg, dprod_next;
    logic [EW-1:0]            eprod_reg, eprod_next;
    logic                     valid_reg, valid_next;

    logic [PW-1:0]            mv_prod;
    logic [NW-1:0]            numer;
    logic [QW-1:0]            fold_hi;
    logic [SAMPLE_BITS-1:0]   fold_lo;
    logic [BW-1:0]            excess;

    // Shared pieces of the datapath.
    always_comb
    begin
        mv_prod  = PW'(peak_reg) * PW'(MV_FULL);
        numer    = {mv_prod, {FRAC_BITS{1'b0}}} + ROUND_HALF;
        fold_hi  = rem_reg[NW-1:SAMPLE_BITS];
        fold_lo  = rem_reg[SAMPLE_BITS-1:0];
        excess   = quo_reg - baseline_reg;
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CALC_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = (peak == '0) ? CALC_DONE : CALC_MUL;
                end
            end
            CALC_MUL:    state_next = CALC_DIV;
            CALC_DIV:
            begin
                if (count_reg == '0)
                begin
                    state_next = CALC_DECAY;
                end
            end
            CALC_DECAY:  state_next = CALC_UPDATE;
            CALC_UPDATE: state_next = CALC_DENS;
            CALC_DENS:   state_next = CALC_DONE;
            CALC_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = CALC_IDLE;
                end
            end
            default:     state_next = CALC_IDLE;
        endcase
    end

    // Datapath register updates, one step per state.
    always_comb
    begin
        count_next    = count_reg;
        peak_next     = peak_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        baseline_next = baseline_reg;
        dprod_next    = dprod_reg;
        eprod_next    = eprod_reg;
        valid_next    = valid_reg;
        case (state_reg)
            CALC_IDLE:
            begin
                if (ctrl.start)
                begin
                    peak_next  = peak;
                    valid_next = peak != '0;
                    eprod_next = '0;
                end
            end
            CALC_MUL:
            begin
                // The whole numerator starts as the remainder, the quotient at zero.
                rem_next   = numer;
                quo_next   = '0;
                count_next = CW'(FOLD_STEPS - 1);
            end
            CALC_DIV:
            begin
                // Full scale is one below a power of two, so the upper part of the
                // remainder moves into the quotient and is added back to the lower
                // part. Once nothing is left above, a remainder equal to full scale
                // gives one more quotient step.
                if (fold_hi != '0)
                begin
                    quo_next = quo_reg + fold_hi;
                    rem_next = NW'(fold_hi) + NW'(fold_lo);
                end
                else if (fold_lo == SAMPLE_BITS'(FULL_SCALE))
                begin
                    quo_next = quo_reg + 1'b1;
                    rem_next = '0;
                end
                count_next = count_reg - 1'b1;
            end
            CALC_DECAY:
            begin
                // Weight the gap only when the reading lies below the baseline.
                if (quo_reg < baseline_reg)
                begin
                    dprod_next = DW'(baseline_reg - quo_reg) * DW'(coef);
                end
                else
                begin
                    dprod_next = '0;
                end
            end
            CALC_UPDATE:
            begin
                baseline_next = baseline_reg - dprod_reg[COEF_SHIFT +: BW];
            end
            CALC_DENS:
            begin
                // Divide the whole millivolts of the excess by five.
                if (quo_reg > baseline_reg)
                begin
                    eprod_next = EW'(excess[FRAC_BITS +: MV_BITS]) * EW'(DIV5_RECIP);
                end
                else
                begin
                    eprod_next = '0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Outputs toward the top level.
    always_comb
    begin
        status.busy          = state_reg != CALC_IDLE;
        status.done          = state_reg == CALC_DONE;
        result.density_ugm3  = eprod_reg[DIV5_SHIFT +: DENSITY_BITS];
        result.reading_valid = valid_reg;
        result.baseline_mv   = baseline_reg[FRAC_BITS +: MV_BITS];
    end

    // Control state and baseline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CALC_IDLE;
            count_reg    <= '0;
            baseline_reg <= BASE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            baseline_reg <= baseline_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        peak_reg  <= peak_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dprod_reg <= dprod_next;
        eprod_reg <= eprod_next;
        valid_reg <= valid_next;
    end

endmodule

`default_nettype wire

// ----- src/dust_peak_baseline_tracker_unit.sv -----
`default_nettype none

// Dust sensor peak and baseline tracker.
// The input channel (in_valid, in_stall, in_data) takes one converter word per
// sensor pulse. Each word fills one slot of the peak window, whether or not its
// conversion succeeded. A word that does not close the window is taken while
// the arithmetic is idle and gives no result. A word that closes the window
// starts the window-end arithmetic, and in_stall stays high until its result is
// handed to the output register. The division by full scale runs as five fold
// steps. The output channel (out_valid, out_stall, out_data) carries one result
// word per window. While the receiver stalls, the result holds in the output
// register, and sample words are still taken until one closes the window. The
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while the block is idle, as the block
// itself does not enforce this. Reset clears the window, loads the default
// window length and decay weight, and sets the clean-air baseline to 900 mV.

module dust_peak_baseline_tracker_unit
    import dpbt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire in_word_t                  in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output out_word_t                      out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [WINDOW_BITS-1:0] window_len_reg;
    logic [COEF_BITS-1:0]   coef_reg;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [WINDOW_BITS-1:0] slot_reg, slot_next;
    logic                   out_valid_reg;
    out_word_t              out_data_reg;

    logic                   in_accept;
    logic [SAMPLE_BITS-1:0] peak_new;
    logic [WINDOW_BITS:0]   len_eff;
    logic [WINDOW_BITS:0]   slot_plus;
    logic                   window_end;
    calc_ctrl_t             ctrl;
    calc_status_t           status;
    out_word_t              result;

    // Window-end arithmetic.
    dpbt_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .peak   (peak_new),
        .coef   (coef_reg),
        .status (status),
        .result (result)
    );

    // Window bookkeeping for the current word.
    always_comb
    begin
        in_accept  = in_valid && !in_stall;
        peak_new   = (in_data.sample_ok && (in_data.adc_sample > peak_reg))
                     ? in_data.adc_sample : peak_reg;
        len_eff    = (window_len_reg == '0) ? (WINDOW_BITS + 1)'(1)
                                            : {1'b0, window_len_reg};
        slot_plus  = {1'b0, slot_reg} + 1'b1;
        window_end = !(slot_plus < len_eff);
        peak_next  = peak_reg;
        slot_next  = slot_reg;
        if (in_accept)
        begin
            if (window_end)
            begin
                peak_next = '0;
                slot_next = '0;
            end
            else
            begin
                peak_next = peak_new;
                slot_next = slot_plus[WINDOW_BITS-1:0];
            end
        end
    end

    // Handshake glue.
    always_comb
    begin
        in_stall   = status.busy;
        cfg_ready  = 1'b1;
        ctrl.start = in_accept && window_end;
        ctrl.take  = status.done && (!out_valid_reg || !out_stall);
        out_valid  = out_valid_reg;
        out_data   = out_data_reg;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_RESET;
            coef_reg       <= COEF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: window_len_reg <= cfg_data[WINDOW_BITS-1:0];
                CFG_DECAY_COEF:    coef_reg       <= cfg_data[COEF_BITS-1:0];
                default:           window_len_reg <= window_len_reg;
            endcase
        end
    end

    // Window state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            peak_reg <= peak_next;
            slot_reg <= slot_next;
            if (ctrl.take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            out_data_reg <= result;
        end
    end

    // A finished result with a free output register shows up next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take |=> out_valid && (out_data == $past(result)))
        else $error("finished result not moved to the output register");

    // The baseline only decays from its reset value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.baseline_mv <= MV_BITS'(MV_RESET)))
        else $error("baseline rose above its reset value");

    // Density stays in range and is zero for an empty window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.density_ugm3 <= DENSITY_BITS'(DENSITY_MAX))
                      && (out_data.reading_valid || (out_data.density_ugm3 == '0)))
        else $error("density out of range");

    // A new window cannot start while the arithmetic is still at work.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.busy && !status.done |=> !$past(ctrl.start) || status.busy)
        else $error("arithmetic unit restarted while busy");

endmodule

`default_nettype wire

// ----- sim/tb_dust_peak_baseline_tracker_unit.sv -----
module tb_dust_peak_baseline_tracker_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import dpbt_pkg::*;

    // Arithmetic constants of the tracker, kept apart from the design's own.
    localparam int              FRAC          = 16;
    localparam longint unsigned MV_SPAN       = 2600;
    localparam longint unsigned FULL_CODE     = 4095;
    localparam longint unsigned DENSITY_STEP  = 5;
    localparam int              BASE_RESET_MV = 900;

    // Run control.
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 240;
    localparam int CYCLE_LIMIT   = 400000;

    // An index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 4'd15;

    // Keeps its own copy of the window, baseline and registers, and holds the
    // window-end readings that are due on the output channel.
    class dust_reading_scoreboard;
        bit [7:0]            win_len;
        bit [15:0]           decay;
        bit [11:0]           peak;
        bit [7:0]            slots;
        bit [FRAC+11:0]      baseline;
        out_word_t           due_readings[$];
        int                  errors;

        function new();
            win_len  = 8'd20;
            decay    = 16'd66;
            peak     = '0;
            slots    = '0;
            baseline = (FRAC+12)'(BASE_RESET_MV) << FRAC;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_WINDOW_LENGTH)
                win_len = data[7:0];
            else if (idx == CFG_DECAY_COEF)
                decay = data;
        endfunction

        // Folds one accepted sample word into the window and, at the window's
        // end, works out the reading that the block must report.
        function void take_sample(in_word_t w);
            int unsigned     len;
            longint unsigned reading;
            out_word_t       want;
            len = (win_len == 0) ? 1 : win_len;
            if (w.sample_ok && w.adc_sample > peak)
                peak = w.adc_sample;
            if (slots + 1 < len)
            begin
                slots = slots + 8'd1;
                return;
            end
            want = '0;
            if (peak != 0)
            begin
                want.reading_valid = 1'b1;
                reading = peak;
                reading = (reading * MV_SPAN * (64'd1 << FRAC) + FULL_CODE / 2) / FULL_CODE;
                // The baseline only ever moves down, toward a lower reading.
                if (reading < baseline)
                    baseline = baseline - (FRAC+12)'(((baseline - reading) * decay) >> 16);
                if (reading > baseline)
                    want.density_ugm3 = 10'((reading - baseline) / (DENSITY_STEP << FRAC));
            end
            want.baseline_mv = baseline[FRAC+11:FRAC];
            due_readings.push_back(want);
            peak  = '0;
            slots = '0;
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted result word against the oldest reading due.
        function void match_reading(out_word_t got);
            out_word_t want;
            if (due_readings.size() == 0)
            begin
                $display("%0t: result word with none expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = due_readings.pop_front();
            compare_field("density_ugm3", 16'(want.density_ugm3), 16'(got.density_ugm3));
            compare_field("reading_valid", 16'(want.reading_valid), 16'(got.reading_valid));
            compare_field("baseline_mv", 16'(want.baseline_mv), 16'(got.baseline_mv));
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    in_word_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_word_t                 out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    dust_reading_scoreboard sb;
    int  send_idle_pct  = 23;
    int  recv_stall_pct = 79;
    bit  pressure_on    = 1'b0;
    bit  hold_done      = 1'b0;
    int  hold_left      = 0;
    bit  dark_window    = 1'b0;
    int  cycle_count    = 0;

    dust_peak_baseline_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: checks each accepted result word, stalls at random, and once
    // holds off for a long stretch so that the block backs up into its input.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_reading(out_data);
        if (pressure_on && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Writes both registers and the spare index in one burst; valid stays up
    // between the words.
    task automatic set_config(logic [7:0] win, logic [15:0] coef);
        logic [CFG_INDEX_BITS-1:0] idx [3];
        logic [CFG_DATA_BITS-1:0]  val [3];
        idx[0] = CFG_WINDOW_LENGTH;
        val[0] = {8'($urandom_range(0, 255)), win};
        idx[1] = CFG_DECAY_COEF;
        val[1] = coef;
        idx[2] = CFG_SPARE_INDEX;
        val[2] = 16'($urandom_range(0, 65535));
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Offers one sample word after an optional random gap and waits for it
    // to be taken.
    task automatic send_sample(in_word_t w);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        sb.take_sample(w);
    endtask

    // Stops offering words, waits for every due reading, then lets the
    // window-end arithmetic run out before anything is reconfigured.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random sample word. Some windows are dark (all zero or failed reads) so
    // that zero-peak results come up regularly.
    function automatic in_word_t pick_sample();
        in_word_t    w;
        int unsigned sel;
        if (sb.slots == 0)
            dark_window = ($urandom_range(0, 99) < 10);
        w.sample_ok = ($urandom_range(0, 99) < 85);
        sel = $urandom_range(0, 9);
        case (sel)
            0:       w.adc_sample = 12'd0;
            1:       w.adc_sample = 12'd4095;
            2:       w.adc_sample = 12'($urandom_range(1, 15));
            default: w.adc_sample = 12'($urandom_range(0, 4095));
        endcase
        if (dark_window && w.sample_ok)
            w.adc_sample = 12'd0;
        return w;
    endfunction

    task automatic run_phase(logic [7:0] win, logic [15:0] coef, int count);
        set_config(win, coef);
        repeat (count) send_sample(pick_sample());
        settle();
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles now and then, receiver stalls most of the time.
        send_idle_pct  = 23;
        recv_stall_pct = 79;

        // One-slot windows: full scale, zero peak, a failed full-scale read,
        // and a tiny reading pulling the baseline down by the default weight.
        set_config(8'd1, 16'd66);
        send_sample(in_word_t'{12'd4095, 1'b1});
        send_sample(in_word_t'{12'd0, 1'b1});
        send_sample(in_word_t'{12'd4095, 1'b0});
        send_sample(in_word_t'{12'd1, 1'b1});
        settle();

        // Largest weight: baseline drops almost to the reading, then the
        // density goes to its top end.
        set_config(8'd1, 16'd65535);
        send_sample(in_word_t'{12'd1, 1'b1});
        send_sample(in_word_t'{12'd4095, 1'b1});
        send_sample(in_word_t'{12'd2048, 1'b1});
        settle();

        // A window length of zero behaves as one slot.
        set_config(8'd0, 16'd0);
        send_sample(in_word_t'{12'd100, 1'b1});
        send_sample(in_word_t'{12'd0, 1'b0});
        settle();

        // Failed reads fill a slot without touching the peak; the second
        // window is left two slots in.
        set_config(8'd3, 16'd32768);
        send_sample(in_word_t'{12'd5, 1'b1});
        send_sample(in_word_t'{12'd4095, 1'b0});
        send_sample(in_word_t'{12'd7, 1'b1});
        send_sample(in_word_t'{12'd3000, 1'b1});
        send_sample(in_word_t'{12'd0, 1'b1});
        settle();

        // Shortening the window below the slots used ends it at the next word.
        set_config(8'd1, 16'd32768);
        send_sample(in_word_t'{12'd1, 1'b1});
        settle();

        run_phase(8'd1, 16'd66, 100);
        run_phase(8'd6, 16'd65535, 150);
        run_phase(8'd255, 16'd12345, 255);

        // Sender idles most of the time, receiver stalls now and then.
        send_idle_pct  = 79;
        recv_stall_pct = 23;
        run_phase(8'd0, 16'd0, 100);
        run_phase(8'd3, 16'd300, 150);
        run_phase(8'd20, 16'd65535, 200);

        // No idling on either side; one long hold-off backs the block up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(8'd2, 16'd7000, 150);
        pressure_on = 1'b1;
        run_phase(8'd1, 16'd65535, 150);
        run_phase(8'd9, 16'd1, 95);

        if (sb.errors == 0 && sb.due_readings.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
